// ===== design/arcl_pkg.sv =====
// Shared types and constants for the angular range coverage list.
`default_nettype none
package arcl_pkg;
  localparam int MAX_RANGES_DEF = 32;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int IN_W = 17;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic start_item;  // latch input item
    logic start_half;  // begin a plain add/query half (second = 1 for upper half)
    logic second;
    logic scan_rd;     // issue read of entry at scan index
    logic scan_eval;   // evaluate read data
    logic shift_step;  // one move step of insert/remove
    logic clear;
    logic finish;      // latch result
  } arcl_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_add;
    logic is_query;
    logic is_clear;
    logic wraps;
    logic half_done;   // current half finished (no shift pending)
    logic shift_busy;  // shift operation pending
  } arcl_sts_t;
endpackage
`default_nettype wire

// ===== design/arcl_datapath.sv =====
// Datapath: interval store, scan evaluation and shift engine.
`default_nettype none
module arcl_datapath #(
  parameter int MAX_RANGES = arcl_pkg::MAX_RANGES_DEF,
  parameter int ANGLE_BITS = arcl_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire arcl_pkg::arcl_cmd_t cmd,
  output arcl_pkg::arcl_sts_t      sts,
  input  wire logic [1:0]          mode,
  input  wire logic [arcl_pkg::IN_W-1:0] from_angle,
  input  wire logic [arcl_pkg::IN_W-1:0] to_angle,
  output logic                     visible,
  output logic                     full_circle,
  output logic                     overflow
);
  localparam int AW = ANGLE_BITS + 1;
  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [AW-1:0] FULL = AW'(1) << ANGLE_BITS;
  localparam int XW = (AW > arcl_pkg::IN_W) ? AW : arcl_pkg::IN_W;

  // shift operation kinds
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;

  logic [AW-1:0] mem_s [MAX_RANGES];
  logic [AW-1:0] mem_e [MAX_RANGES];
  logic [AW-1:0] rd_s, rd_e;
  logic [IW-1:0] rd_a;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;     // scan index
  logic [1:0]    it_mode;
  logic [arcl_pkg::IN_W-1:0] it_from, it_to;
  logic [XW-1:0] lo, hi;  // current half bounds (query unclamped)
  logic          merging; // absorbing following intervals into entry m_pos
  logic [CW-1:0] m_pos;
  logic [AW-1:0] m_end;   // running end of merged entry
  logic [AW-1:0] mem_s_hold;
  logic          done;
  logic          vis_acc, vis_half, ovf_acc;
  logic [1:0]    op;
  logic [CW-1:0] sh_k, sh_pos;
  logic [AW-1:0] ins_lo, ins_hi;
  logic          first_full;
  logic          wr_en;
  logic [IW-1:0] wr_a;
  logic [AW-1:0] wr_s, wr_e;

  function automatic logic [XW-1:0] clampx(input logic [arcl_pkg::IN_W-1:0] a);
    logic [XW-1:0] x;
    x = XW'(a);
    return (x > XW'(FULL)) ? XW'(FULL) : x;
  endfunction

  assign sts.is_add     = (it_mode == arcl_pkg::MODE_ADD);
  assign sts.is_query   = (it_mode == arcl_pkg::MODE_QUERY);
  assign sts.is_clear   = (it_mode == arcl_pkg::MODE_CLEAR);
  assign sts.wraps      = (it_from > it_to);
  assign sts.half_done  = done && (op == OP_NONE);
  assign sts.shift_busy = (op != OP_NONE);

  // insert walks down from the top, remove reads the entry above
  assign rd_a = (op == OP_INS) ? IW'(sh_k - CW'(1))
              : IW'(cmd.shift_step ? sh_k + CW'(1) : idx);

  // memory read (registered)
  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.shift_step) begin
      rd_s <= mem_s[rd_a];
      rd_e <= mem_e[rd_a];
    end
    if (wr_en) begin
      mem_s[wr_a] <= wr_s;
      mem_e[wr_a] <= wr_e;
    end
  end

  // shift engine: each step alternates read (phase 0) and write (phase 1)
  logic sh_ph;

  always_comb begin
    wr_en = 1'b0;
    wr_a  = '0;
    wr_s  = rd_s;
    wr_e  = rd_e;
    if (cmd.shift_step && sh_ph) begin
      if (op == OP_INS) begin
        wr_en = 1'b1;
        wr_a  = IW'(sh_k);
        if (sh_k == sh_pos) begin
          wr_s = ins_lo;
          wr_e = ins_hi;
        end
      end else begin
        wr_en = (sh_k + CW'(1) < count);
        wr_a  = IW'(sh_k);
      end
    end else if (cmd.scan_eval && !done && !merging && count != '0 && idx < count) begin
      // extend start in place when overlapping
      if (!(XW'(rd_e) < lo) && !(hi < XW'(rd_s)) && sts.is_add && lo < XW'(rd_s)) begin
        wr_en = 1'b1;
        wr_a  = IW'(idx);
        wr_s  = AW'(lo);
        wr_e  = rd_e;
      end
    end else if (cmd.scan_eval && merging && !done) begin
      // finishing a merge writes the final end
      if (!(idx < count && XW'(rd_s) <= hi)) begin
        wr_en = 1'b1;
        wr_a  = IW'(m_pos);
        wr_s  = mem_s_hold;
        wr_e  = (hi > XW'(m_end)) ? AW'(hi) : m_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      op       <= OP_NONE;
      done     <= 1'b0;
      merging  <= 1'b0;
      sh_ph    <= 1'b0;
      visible  <= 1'b0;
      overflow <= 1'b0;
      full_circle <= 1'b0;
      first_full  <= 1'b0;
    end else begin
      if (cmd.start_item) begin
        it_mode <= mode;
        it_from <= from_angle;
        it_to   <= to_angle;
        vis_acc <= 1'b0;
        ovf_acc <= 1'b0;
      end
      if (cmd.start_half) begin
        idx      <= '0;
        done     <= 1'b0;
        merging  <= 1'b0;
        vis_half <= 1'b1;
        if (it_mode == arcl_pkg::MODE_ADD) begin
          lo <= cmd.second ? clampx(it_from) : ((it_from > it_to) ? '0 : clampx(it_from));
          hi <= cmd.second ? XW'(FULL) : clampx(it_to);
        end else begin
          lo <= cmd.second ? XW'(it_from) : ((it_from > it_to) ? '0 : XW'(it_from));
          hi <= cmd.second ? XW'(FULL) : XW'(it_to);
        end
      end
      if (cmd.scan_eval && !done) begin
        if (sts.is_query) begin
          if (idx >= count) begin
            done <= 1'b1;
          end else begin
            if (lo >= XW'(rd_s) && hi <= XW'(rd_e)) vis_half <= 1'b0;
            idx <= idx + CW'(1);
          end
        end else if (merging) begin
          if (idx < count && XW'(rd_s) <= hi) begin
            // absorb entry idx into m_pos: remove it
            m_end   <= rd_e;
            done    <= 1'b0;
            op      <= OP_REM;
            sh_k    <= idx;
            sh_ph   <= 1'b0;
          end else begin
            done    <= 1'b1;
            merging <= 1'b0;
          end
        end else if (idx >= count) begin
          done <= 1'b1;
          if (count >= CW'(MAX_RANGES)) ovf_acc <= 1'b1;
          else begin
            op <= OP_INS; sh_k <= count; sh_pos <= count; sh_ph <= 1'b0;
            ins_lo <= AW'(lo); ins_hi <= AW'(hi);
          end
        end else if (XW'(rd_e) < lo) begin
          idx <= idx + CW'(1);
        end else if (hi < XW'(rd_s)) begin
          done <= 1'b1;
          if (count >= CW'(MAX_RANGES)) ovf_acc <= 1'b1;
          else begin
            op <= OP_INS; sh_k <= count; sh_pos <= idx; sh_ph <= 1'b0;
            ins_lo <= AW'(lo); ins_hi <= AW'(hi);
          end
        end else if (hi <= XW'(rd_e)) begin
          done <= 1'b1;
        end else begin
          merging    <= 1'b1;
          m_pos      <= idx;
          m_end      <= rd_e;
          mem_s_hold <= (lo < XW'(rd_s)) ? AW'(lo) : rd_s;
          idx        <= idx + CW'(1);
        end
      end
      if (cmd.shift_step) begin
        sh_ph <= ~sh_ph;
        if (sh_ph) begin
          if (op == OP_INS) begin
            if (sh_k == sh_pos) begin
              op    <= OP_NONE;
              count <= count + CW'(1);
            end else sh_k <= sh_k - CW'(1);
          end else begin
            if (sh_k + CW'(1) >= count) begin
              op    <= OP_NONE;
              count <= count - CW'(1);
            end else sh_k <= sh_k + CW'(1);
          end
        end
      end
      if (cmd.clear) count <= '0;
      if (wr_en && wr_a == '0) first_full <= (wr_s == '0) && (wr_e == FULL);
      if (cmd.finish) begin
        visible     <= sts.is_query && (vis_acc || vis_half);
        overflow    <= ovf_acc;
        full_circle <= (count != '0) && first_full && !cmd.clear;
      end
      if (cmd.start_half && cmd.second) vis_acc <= vis_half;
    end
  end
endmodule
`default_nettype wire

// ===== design/arcl_ctrl.sv =====
// Controller state machine sequencing scans and shifts.
`default_nettype none
module arcl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  output logic                     busy,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output arcl_pkg::arcl_cmd_t      cmd,
  input  wire arcl_pkg::arcl_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HALF = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_SH   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state, state_next;
  logic       second, second_next;

  always_comb begin
    cmd = '0;
    state_next  = state;
    second_next = second;
    cmd.second  = second;
    case (state)
      S_IDLE: if (in_fire) begin
        cmd.start_item = 1'b1;
        second_next = 1'b0;
        state_next = S_HALF;
      end
      S_HALF: begin
        if (sts.is_clear) begin
          cmd.clear = 1'b1;
          state_next = S_FIN;
        end else if (!sts.is_add && !sts.is_query) state_next = S_FIN;
        else begin
          cmd.start_half = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.scan_rd = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        cmd.scan_eval = 1'b1;
        state_next = S_SH;
      end
      S_SH: begin
        if (sts.shift_busy) cmd.shift_step = 1'b1;
        else if (sts.half_done) begin
          if (sts.wraps && !second) begin
            second_next = 1'b1;
            state_next = S_HALF;
          end else state_next = S_FIN;
        end else state_next = S_RD;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end
endmodule
`default_nettype wire

// ===== design/angular_range_coverage_list.sv =====
// Top level of the angular range coverage list.
//
// channel | dir | tdata (low bit up)                        | tuser
// s_axis  | in  | mode[1:0], from_angle[18:2], to_angle[35:19] | -
// m_axis  | out | visible[0], full_circle[1], overflow[2]    | -
//
// One item at a time. Each scanned interval passes through read, evaluate and
// check states; accept, setup, finish and output states frame each item, a
// wrapped item scans both halves, and clear and the unused mode skip the scan.
// Each entry moved by an insert or a merge removal costs a read step and a
// write step (one memory port); a merge across the whole store moves the
// remaining entries again for each absorbed interval.
// Reset (rst, synchronous) empties the store at once; no clearing pass.
// The result register holds until taken; s_axis_tready is low meanwhile.
`default_nettype none
module angular_range_coverage_list #(
  parameter int MAX_RANGES = arcl_pkg::MAX_RANGES_DEF,
  parameter int ANGLE_BITS = arcl_pkg::ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // mode, from_angle, to_angle, zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // visible, full_circle, overflow, zero pad
);
  arcl_pkg::arcl_cmd_t cmd;
  arcl_pkg::arcl_sts_t sts;
  logic busy, vis, full, ovf;
  logic in_fire;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {5'd0, ovf, full, vis};

  arcl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .busy(busy),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .cmd(cmd), .sts(sts)
  );

  arcl_datapath #(.MAX_RANGES(MAX_RANGES), .ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .mode(s_axis_tdata[1:0]), .from_angle(s_axis_tdata[18:2]),
    .to_angle(s_axis_tdata[35:19]),
    .visible(vis), .full_circle(full), .overflow(ovf)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_vis_mode: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("accepted item not in work");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_angular_range_coverage_list.sv =====
// Testbench for the angular range coverage list: directed table plus random traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb_angular_range_coverage_list;

  localparam int NSLOT = 32;
  localparam logic [16:0] FULL = 17'h10000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  always #6 clk = ~clk;

  angular_range_coverage_list dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // predictor's copy of the interval store
  logic [16:0] span_lo [NSLOT];
  logic [16:0] span_hi [NSLOT];
  int          span_cnt;

  logic [2:0] flags_due[$];   // {overflow, full_circle, visible}
  int errors;

  function automatic logic [16:0] clampa(logic [16:0] a);
    return (a > FULL) ? FULL : a;
  endfunction

  function automatic bit put_span(int pos, logic [16:0] lo, logic [16:0] hi);
    if (span_cnt >= NSLOT) return 1'b1;
    for (int k = span_cnt; k > pos; k--) begin
      span_lo[k] = span_lo[k-1];
      span_hi[k] = span_hi[k-1];
    end
    span_lo[pos] = lo;
    span_hi[pos] = hi;
    span_cnt++;
    return 1'b0;
  endfunction

  function automatic void drop_span(int pos);
    for (int k = pos; k + 1 < span_cnt; k++) begin
      span_lo[k] = span_lo[k+1];
      span_hi[k] = span_hi[k+1];
    end
    span_cnt--;
  endfunction

  // insert a non-wrapping range, merging neighbors; 1 if dropped for room
  function automatic bit merge_span(logic [16:0] lo_in, logic [16:0] hi_in);
    logic [16:0] lo, hi;
    lo = clampa(lo_in);
    hi = clampa(hi_in);
    for (int i = 0; i < span_cnt; i++) begin
      if (span_hi[i] < lo) continue;
      if (hi < span_lo[i]) return put_span(i, lo, hi);
      if (span_lo[i] <= lo && span_hi[i] >= hi) return 1'b0;
      if (lo < span_lo[i]) span_lo[i] = lo;
      if (hi <= span_hi[i]) return 1'b0;
      while (i + 1 < span_cnt && span_lo[i+1] <= hi) begin
        span_hi[i] = span_hi[i+1];
        drop_span(i + 1);
      end
      if (hi > span_hi[i]) span_hi[i] = hi;
      return 1'b0;
    end
    return put_span(span_cnt, lo, hi);
  endfunction

  function automatic bit seen(logic [16:0] lo, logic [16:0] hi);
    for (int i = 0; i < span_cnt; i++)
      if (lo >= span_lo[i] && hi <= span_hi[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [2:0] predict_flags(logic [1:0] md, logic [16:0] fa,
                                               logic [16:0] ta);
    bit vis, ovf, full, a, b;
    vis = 0; ovf = 0;
    if (md == arcl_pkg::MODE_ADD) begin
      if (fa > ta) begin
        a = merge_span(17'd0, ta);
        b = merge_span(fa, FULL);
        ovf = a | b;
      end else ovf = merge_span(fa, ta);
    end else if (md == arcl_pkg::MODE_QUERY) begin
      vis = (fa > ta) ? (seen(17'd0, ta) || seen(fa, FULL)) : seen(fa, ta);
    end else if (md == arcl_pkg::MODE_CLEAR) begin
      span_cnt = 0;
    end
    full = span_cnt > 0 && span_lo[0] == 17'd0 && span_hi[0] == FULL;
    return {ovf, full, vis};
  endfunction

  // stimulus items built up front; each row may carry a hand-typed result
  typedef struct {
    logic [1:0]  md;
    logic [16:0] fa;
    logic [16:0] ta;
    bit          typed;
    logic [2:0]  flags;
  } row_t;

  row_t plan[$];
  int   pause_at;   // sender waits for drain before this index

  function automatic void row(logic [1:0] md, logic [16:0] fa, logic [16:0] ta,
                              bit typed = 0, logic [2:0] fl = 3'b000);
    row_t r;
    r.md = md; r.fa = fa; r.ta = ta; r.typed = typed; r.flags = fl;
    plan.push_back(r);
  endfunction

  function automatic logic [16:0] rand_angle();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return FULL;
      2: return 17'($urandom_range(17'h1FFFF, 17'h10001));  // above full circle
      3: return 17'($urandom_range(255) * 256);             // coarse, touching ends
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic void build_plan();
    logic [16:0] b;
    // directed table
    row(arcl_pkg::MODE_QUERY, 17'd0, 17'd100, 1, 3'b001);        // empty set visible
    row(arcl_pkg::MODE_ADD, 17'd100, 17'd200, 1, 3'b000);
    row(arcl_pkg::MODE_QUERY, 17'd120, 17'd180, 1, 3'b000);
    row(arcl_pkg::MODE_QUERY, 17'd90, 17'd180, 1, 3'b001);
    row(arcl_pkg::MODE_ADD, 17'd200, 17'd300);                   // touching end merges
    row(arcl_pkg::MODE_ADD, 17'd50, 17'd100);
    row(arcl_pkg::MODE_ADD, 17'd60000, 17'd10);                  // wrapping add
    row(arcl_pkg::MODE_QUERY, 17'd60001, 17'd5);                 // wrapping query
    row(arcl_pkg::MODE_QUERY, 17'd400, 17'd5);
    row(arcl_pkg::MODE_ADD, 17'h1FFFF, 17'h1FFFF);               // clamps to full
    row(arcl_pkg::MODE_QUERY, 17'h1FFFF, 17'h1FFFF);             // raw compare, visible
    row(arcl_pkg::MODE_UNUSED, 17'd5, 17'd6);                    // unused mode
    row(arcl_pkg::MODE_ADD, 17'd0, 17'd65536, 1, 3'b010);        // full circle
    row(arcl_pkg::MODE_QUERY, 17'd0, 17'd65536, 1, 3'b010);
    row(arcl_pkg::MODE_UNUSED, 17'h1FFFF, 17'h0, 1, 3'b010);
    row(arcl_pkg::MODE_CLEAR, 17'h1FFFF, 17'h1FFFF, 1, 3'b000);
    // fill the store to capacity, then overflow
    for (int i = 0; i < 33; i++)
      row(arcl_pkg::MODE_ADD, 17'(i * 1000), 17'(i * 1000 + 10));
    row(arcl_pkg::MODE_ADD, 17'd500, 17'd510, 1, 3'b100);        // store full, dropped
    row(arcl_pkg::MODE_ADD, 17'd5, 17'd1000);                    // merge still works
    row(arcl_pkg::MODE_CLEAR, 17'd0, 17'd0, 1, 3'b000);
    pause_at = plan.size();
    // random: well-formed episodes of adds and queries, some clears
    while (plan.size() < 600) begin
      if ($urandom_range(9) == 0) row(arcl_pkg::MODE_CLEAR, rand_angle(), rand_angle());
      else if ($urandom_range(19) == 0)
        row(arcl_pkg::MODE_UNUSED, rand_angle(), rand_angle());
      else if ($urandom_range(1)) row(arcl_pkg::MODE_ADD, rand_angle(), rand_angle());
      else begin
        // queries aimed near stored edges so hidden cases occur
        b = 17'($urandom_range(65000));
        if ($urandom_range(1))
          row(arcl_pkg::MODE_QUERY, b, 17'(b + $urandom_range(300)));
        else row(arcl_pkg::MODE_QUERY, rand_angle(), rand_angle());
      end
      // small random adds between to raise the count and overflow chance
      if ($urandom_range(7) == 0)
        for (int k = 0; k < 12; k++) begin
          b = 17'($urandom_range(65000));
          row(arcl_pkg::MODE_ADD, b, 17'(b + $urandom_range(20)));
        end
    end
  endfunction

  // typed results from the table, aligned with the result queue
  bit         typed_due[$];
  logic [2:0] typed_val[$];
  int         sent;
  bit         sending_done;
  int         hold_off;     // receiver long stall counter

  // sender: bursts with gaps
  initial begin : sender
    int burst, gap;
    logic [2:0] fl;
    build_plan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    sent = 0;
    while (sent < plan.size()) begin
      burst = $urandom_range(1, 12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 80);
      if (gap != 0) s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      for (int j = 0; j < burst && sent < plan.size(); j++) begin
        if (sent == pause_at && flags_due.size() != 0) begin
          s_axis_tvalid <= 1'b0;
          while (flags_due.size() != 0) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, plan[sent].ta, plan[sent].fa, plan[sent].md};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        fl = predict_flags(plan[sent].md, plan[sent].fa, plan[sent].ta);
        flags_due.push_back(fl);
        typed_due.push_back(plan[sent].typed);
        typed_val.push_back(plan[sent].flags);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver: own stall pattern, one long hold-off early
  initial begin : receiver
    int phase;
    phase = 0;
    hold_off = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      phase++;
      if (phase > 300 && phase < 2300) begin
        hold_off++;
        m_axis_tready <= 1'b0;
      end else if (phase % 97 < 40)
        m_axis_tready <= 1'b1;
      else
        m_axis_tready <= ($urandom_range(3) != 0);
    end
  end

  // result check on each transfer
  always @(posedge clk) begin
    logic [2:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (flags_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %b", m_axis_tdata[2:0]);
      end else begin
        want = flags_due.pop_front();
        if (typed_due.pop_front() && typed_val[0] != want) begin
          errors++;
          if (errors <= 10) $display("table row: typed %b predicted %b", typed_val[0], want);
        end
        void'(typed_val.pop_front());
        if (m_axis_tdata[2:0] != want || m_axis_tdata[7:3] != 5'b0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected ovf/full/vis %b, got %b (tdata %h)",
                     want, m_axis_tdata[2:0], m_axis_tdata);
        end
      end
    end
  end

  initial begin : finisher
    errors = 0;
    sending_done = 1'b0;
    wait (sending_done);
    while (flags_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && flags_due.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #(12 * 10000000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/arcl_pkg.sv
design/arcl_datapath.sv
design/arcl_ctrl.sv
design/angular_range_coverage_list.sv
bench/tb_angular_range_coverage_list.sv
